/* hdl/sps_pkg.sv */
// Shared constants, types and register codes for the sphere point sampler.
package sps_pkg;

    localparam int FRAC_BITS_DEF   = 30;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int GEN_W  = 31;
    localparam int COORD_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [14:0]      LEHMER_MUL = 15'd16807;
    localparam logic [GEN_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

    localparam logic [GEN_W-1:0] SEED_FIRST_RST  = 31'd1;
    localparam logic [GEN_W-1:0] SEED_SECOND_RST = 31'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_SEED_FIRST  = 1'b0;
    localparam logic REG_SEED_SECOND = 1'b1;

    typedef struct packed {
        logic             wr_first;
        logic             wr_second;
        logic [GEN_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [GEN_W-1:0] gen_first;
        logic [GEN_W-1:0] gen_second;
    } t_cand;

endpackage

/* hdl/sphere_point_sampler.sv */
// An accepted draw is registered into the queue. A candidate inside the disk passes
// the square, sum, root (one bit per cycle), scale and done states; a rejected one
// skips root and scale. A new candidate starts only once the last is in the result
// register. Idle transactions are dropped; up to QUEUE_DEPTH draws buffer ahead.
// Reset (synchronous, active low): seeds return to 1 and 2, generators reload from them,
// queue and result register empty.
module sphere_point_sampler #(
    parameter int FRAC_BITS   = sps_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sps_pkg::ADDR_W-1:0]         paddr,
    input  logic [sps_pkg::DATA_W-1:0]         pwdata,
    output logic [sps_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // draw channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_draw,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_accepted,
    output logic signed [sps_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [sps_pkg::COORD_W-1:0] o_coord_y,
    output logic signed [sps_pkg::COORD_W-1:0] o_coord_z
);

    sps_pkg::t_cfg_wr          cfg_wr;
    sps_pkg::t_cand            push_cand, pop_cand;
    logic                      push, pop, q_full, q_valid;
    logic                      cfg_write;
    logic [sps_pkg::GEN_W-1:0] seed_first, seed_second;

    // Decode the write transaction; the word address picks the seed register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign cfg_wr.wr_first  = cfg_write && (paddr[2] == sps_pkg::REG_SEED_FIRST);
    assign cfg_wr.wr_second = cfg_write && (paddr[2] == sps_pkg::REG_SEED_SECOND);
    assign cfg_wr.data      = pwdata[sps_pkg::GEN_W-1:0];

    // Read back the stored seed, zero-extended
    assign prdata = (paddr[2] == sps_pkg::REG_SEED_FIRST) ?
                    sps_pkg::DATA_W'(seed_first) : sps_pkg::DATA_W'(seed_second);

    // Front end: advance both generators on every draw transaction, drop idle ones
    sps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_valid      (i_valid),
        .i_draw       (i_draw),
        .o_stall      (o_stall),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cand       (push_cand),
        .o_seed_first (seed_first),
        .o_seed_second(seed_second)
    );

    // Hold fresh generator pairs until the back end is free
    sps_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cand (push_cand),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cand (pop_cand)
    );

    // Back end: disk test, root, scale; the result register lets the next pair start
    sps_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cand    (pop_cand),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_accepted(o_accepted),
        .o_coord_x (o_coord_x),
        .o_coord_y (o_coord_y),
        .o_coord_z (o_coord_z)
    );

endmodule

/* hdl/sps_front.sv */
// Front end: seed registers, the two Lehmer generators and draw intake.
module sps_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sps_pkg::t_cfg_wr           i_cfg,
    input  logic                       i_valid,
    input  logic                       i_draw,
    output logic                       o_stall,
    input  logic                       i_q_full,
    output logic                       o_push,
    output sps_pkg::t_cand             o_cand,
    output logic [sps_pkg::GEN_W-1:0]  o_seed_first,
    output logic [sps_pkg::GEN_W-1:0]  o_seed_second
);

    // z * 16807 mod 2^31-1: fold the high part onto the low part, one correction
    function automatic logic [sps_pkg::GEN_W-1:0] lehmer_next(
        input logic [sps_pkg::GEN_W-1:0] z
    );
        logic [45:0] p;
        logic [31:0] s;
        p = 46'(z) * 46'(sps_pkg::LEHMER_MUL);
        s = 32'(p[30:0]) + 32'(p[45:31]);
        if (s >= 32'(sps_pkg::LEHMER_MOD)) begin
            s = s - 32'(sps_pkg::LEHMER_MOD);
        end
        return s[30:0];
    endfunction

    logic [sps_pkg::GEN_W-1:0] r_seed_first, r_seed_second;
    logic [sps_pkg::GEN_W-1:0] r_gen_first, r_gen_second;
    logic [sps_pkg::GEN_W-1:0] n_gen_first, n_gen_second;

    assign n_gen_first  = lehmer_next(r_gen_first);
    assign n_gen_second = lehmer_next(r_gen_second);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && i_draw;
    assign o_cand.gen_first  = n_gen_first;
    assign o_cand.gen_second = n_gen_second;
    assign o_seed_first  = r_seed_first;
    assign o_seed_second = r_seed_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_first  <= sps_pkg::SEED_FIRST_RST;
            r_seed_second <= sps_pkg::SEED_SECOND_RST;
            r_gen_first   <= sps_pkg::SEED_FIRST_RST;
            r_gen_second  <= sps_pkg::SEED_SECOND_RST;
        end else begin
            if (i_cfg.wr_first) begin
                r_seed_first <= i_cfg.data;
                r_gen_first  <= i_cfg.data;
            end else if (o_push) begin
                r_gen_first <= n_gen_first;
            end
            if (i_cfg.wr_second) begin
                r_seed_second <= i_cfg.data;
                r_gen_second  <= i_cfg.data;
            end else if (o_push) begin
                r_gen_second <= n_gen_second;
            end
        end
    end

endmodule

/* hdl/sps_queue.sv */
// Short candidate queue between the front end and the back end.
module sps_queue #(
    parameter int DEPTH = sps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sps_pkg::t_cand  i_cand,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sps_pkg::t_cand  o_cand
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sps_pkg::t_cand   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cand  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* hdl/sps_back.sv */
// Back end: disk test, bit-serial square root, scaling and the result register.
module sps_back #(
    parameter int FRAC_BITS = sps_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  sps_pkg::t_cand                i_cand,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic signed [sps_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [sps_pkg::COORD_W-1:0] o_coord_y,
    output logic signed [sps_pkg::COORD_W-1:0] o_coord_z
);

    localparam int SHIFT = 62 - FRAC_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_SUM    = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_SCALE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [62:0] ONE_Q62 = 63'(1) << 62;

    // Q.62 magnitude to FRAC_BITS fixed point, truncated toward zero
    function automatic logic [31:0] to_fix(input logic [62:0] mag, input logic neg);
        logic [62:0] t;
        t = mag >> SHIFT;
        return neg ? (32'd0 - t[31:0]) : t[31:0];
    endfunction

    // 2z - m as sign and magnitude
    function automatic logic [31:0] to_signmag(input logic [30:0] z);
        logic [31:0] two_z;
        logic [31:0] m;
        two_z = {z, 1'b0};
        m     = 32'(sps_pkg::LEHMER_MOD);
        if (two_z < m) begin
            return {1'b1, 31'(m - two_z)};
        end
        return {1'b0, 31'(two_z - m)};
    endfunction

    logic [2:0]  r_state, n_state;
    logic [30:0] r_umag, r_vmag;
    logic        r_uneg, r_vneg;
    logic [61:0] r_prod_x, r_prod_y;
    logic        r_acc;
    logic [62:0] r_zmag;
    logic        r_zneg;
    logic [61:0] r_rad;
    logic [32:0] r_rem;
    logic [30:0] r_root;
    logic [4:0]  r_cnt;

    logic        r_out_valid;
    logic        r_out_acc;
    logic [31:0] r_out_x, r_out_y, r_out_z;

    logic [31:0] u_sm, v_sm;
    logic [30:0] mul_b;
    logic [61:0] prod_x, prod_y;
    logic [62:0] r2, z2;
    logic [34:0] rem_sh, trial;
    logic        out_load;

    assign u_sm = to_signmag(i_cand.gen_first);
    assign v_sm = to_signmag(i_cand.gen_second);

    // Two shared multipliers: squares first, then scaling by the root
    assign mul_b  = (r_state == S_SQUARE) ? r_umag : r_root;
    assign prod_x = 62'(r_umag) * 62'(mul_b);
    assign prod_y = 62'(r_vmag) * 62'((r_state == S_SQUARE) ? r_vmag : r_root);

    assign r2 = 63'(r_prod_x) + 63'(r_prod_y);
    assign z2 = {r2[61:0], 1'b0};

    // One root bit per cycle
    assign rem_sh = {r_rem, r_rad[61:60]};
    assign trial  = 35'({r_root, 2'b01});

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) n_state = S_SQUARE;
            end
            S_SQUARE: n_state = S_SUM;
            S_SUM: begin
                n_state = r2[62] ? S_DONE : S_ROOT;
            end
            S_ROOT: begin
                if (r_cnt == '0) n_state = S_SCALE;
            end
            S_SCALE: n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_uneg <= u_sm[31];
                    r_umag <= u_sm[30:0];
                    r_vneg <= v_sm[31];
                    r_vmag <= v_sm[30:0];
                end
            end
            S_SQUARE: begin
                r_prod_x <= prod_x;
                r_prod_y <= prod_y;
            end
            S_SUM: begin
                r_acc  <= !r2[62];
                r_rad  <= 62'(ONE_Q62 - r2);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 5'd30;
                if (z2 <= ONE_Q62) begin
                    r_zmag <= ONE_Q62 - z2;
                    r_zneg <= 1'b0;
                end else begin
                    r_zmag <= z2 - ONE_Q62;
                    r_zneg <= 1'b1;
                end
            end
            S_ROOT: begin
                r_rad <= {r_rad[59:0], 2'b00};
                r_cnt <= r_cnt - 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= 33'(rem_sh - trial);
                    r_root <= {r_root[29:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[32:0];
                    r_root <= {r_root[29:0], 1'b0};
                end
            end
            S_SCALE: begin
                r_prod_x <= prod_x;
                r_prod_y <= prod_y;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_acc <= r_acc;
            r_out_x   <= r_acc ? to_fix({r_prod_x, 1'b0}, r_uneg) : '0;
            r_out_y   <= r_acc ? to_fix({r_prod_y, 1'b0}, r_vneg) : '0;
            r_out_z   <= r_acc ? to_fix(r_zmag, r_zneg) : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_acc;
    assign o_coord_x  = r_out_x;
    assign o_coord_y  = r_out_y;
    assign o_coord_z  = r_out_z;

`ifndef SYNTHESIS
    a_root_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_cnt != '0) |=> (r_state == S_ROOT))
        else $error("root loop left early");
    a_root_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_cnt == '0) |=> (r_state == S_SCALE))
        else $error("root loop did not finish");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result load lost");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_acc) |->
            (r_out_x == '0 && r_out_y == '0 && r_out_z == '0))
        else $error("rejected result carries coordinates");
`endif

endmodule

/* bench/sps_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the sphere point sampler: mirrors the generators and checks every point.
module sps_checker #(
    parameter int FRAC_BITS = sps_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [sps_pkg::ADDR_W-1:0]          i_paddr,
    input  logic [sps_pkg::DATA_W-1:0]          i_pwdata,
    input  logic [sps_pkg::DATA_W-1:0]          i_prdata,
    input  logic                                i_draw_valid,
    input  logic                                i_draw_stall,
    input  logic                                i_draw,
    input  logic                                i_pt_valid,
    input  logic                                i_pt_stall,
    input  logic                                i_accepted,
    input  logic signed [sps_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [sps_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [sps_pkg::COORD_W-1:0]  i_coord_z,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] ONE_Q62     = 64'd1 << 62;

    typedef struct packed {
        logic                               accepted;
        logic signed [sps_pkg::COORD_W-1:0] x;
        logic signed [sps_pkg::COORD_W-1:0] y;
        logic signed [sps_pkg::COORD_W-1:0] z;
    } t_sphere_pt;

    t_sphere_pt                expected_pts[$];
    logic [sps_pkg::GEN_W-1:0] seed_u, seed_v;
    logic [sps_pkg::GEN_W-1:0] lcg_u, lcg_v;
    int                        fail_cnt = 0;

    function automatic logic [sps_pkg::GEN_W-1:0] lehmer_advance(
        input logic [sps_pkg::GEN_W-1:0] g
    );
        logic [63:0] prod;
        prod = 64'(g) * 64'(sps_pkg::LEHMER_MUL);
        return sps_pkg::GEN_W'(prod % 64'(sps_pkg::LEHMER_MOD));
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root, trial;
        root = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    // Drop the fraction below FRAC_BITS on the magnitude, then reapply the sign
    function automatic logic [sps_pkg::COORD_W-1:0] q62_to_coord(
        input logic [63:0] mag,
        input logic        neg
    );
        logic [63:0] t;
        t = mag >> (62 - FRAC_BITS);
        if (neg) t = -t;
        return t[sps_pkg::COORD_W-1:0];
    endfunction

    function automatic t_sphere_pt project_candidate(input logic [sps_pkg::GEN_W-1:0] gu,
                                                     input logic [sps_pkg::GEN_W-1:0] gv);
        t_sphere_pt  pt;
        logic [63:0] twice_u, twice_v, mag_u, mag_v, r2, root, r2x2;
        logic        neg_u, neg_v;
        twice_u = 64'(gu) << 1;
        twice_v = 64'(gv) << 1;
        neg_u   = twice_u < 64'(sps_pkg::LEHMER_MOD);
        neg_v   = twice_v < 64'(sps_pkg::LEHMER_MOD);
        mag_u   = neg_u ? 64'(sps_pkg::LEHMER_MOD) - twice_u : twice_u - 64'(sps_pkg::LEHMER_MOD);
        mag_v   = neg_v ? 64'(sps_pkg::LEHMER_MOD) - twice_v : twice_v - 64'(sps_pkg::LEHMER_MOD);
        r2      = mag_u * mag_u + mag_v * mag_v;
        pt      = '0;
        if (r2 < ONE_Q62) begin
            root        = floor_sqrt(ONE_Q62 - r2);
            r2x2        = r2 << 1;
            pt.accepted = 1'b1;
            pt.x        = q62_to_coord((mag_u * root) << 1, neg_u);
            pt.y        = q62_to_coord((mag_v * root) << 1, neg_v);
            pt.z        = (r2x2 <= ONE_Q62) ? q62_to_coord(ONE_Q62 - r2x2, 1'b0)
                                            : q62_to_coord(r2x2 - ONE_Q62, 1'b1);
        end
        return pt;
    endfunction

    always @(posedge i_clk) begin
        t_sphere_pt exp_pt, got_pt;
        if (!i_rst_n) begin
            seed_u = sps_pkg::SEED_FIRST_RST;
            seed_v = sps_pkg::SEED_SECOND_RST;
            lcg_u  = sps_pkg::SEED_FIRST_RST;
            lcg_v  = sps_pkg::SEED_SECOND_RST;
            expected_pts.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == sps_pkg::REG_SEED_FIRST) begin
                        seed_u = i_pwdata[sps_pkg::GEN_W-1:0];
                        lcg_u  = seed_u;
                    end else begin
                        seed_v = i_pwdata[sps_pkg::GEN_W-1:0];
                        lcg_v  = seed_v;
                    end
                end else begin
                    exp_pt = '0;
                    exp_pt.x = {1'b0, (i_paddr[2] == sps_pkg::REG_SEED_FIRST) ? seed_u : seed_v};
                    if (i_prdata !== exp_pt.x) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("register read at %0h: expected %0h, got %0h",
                                     i_paddr, exp_pt.x, i_prdata);
                    end
                end
            end
            // Retire the oldest point before queuing a new one from this edge
            if (i_pt_valid && !i_pt_stall) begin
                got_pt = '{i_accepted, i_coord_x, i_coord_y, i_coord_z};
                if (expected_pts.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("point with nothing expected: acc=%0b x=%0d y=%0d z=%0d",
                                 got_pt.accepted, got_pt.x, got_pt.y, got_pt.z);
                end else begin
                    exp_pt = expected_pts.pop_front();
                    if (got_pt.accepted !== exp_pt.accepted || got_pt.x !== exp_pt.x ||
                        got_pt.y !== exp_pt.y || got_pt.z !== exp_pt.z) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS) begin
                            $display("point mismatch: expected acc=%0b x=%0d y=%0d z=%0d",
                                     exp_pt.accepted, exp_pt.x, exp_pt.y, exp_pt.z);
                            $display("                got      acc=%0b x=%0d y=%0d z=%0d",
                                     got_pt.accepted, got_pt.x, got_pt.y, got_pt.z);
                        end
                    end
                end
            end
            if (i_draw_valid && !i_draw_stall && i_draw) begin
                lcg_u = lehmer_advance(lcg_u);
                lcg_v = lehmer_advance(lcg_v);
                expected_pts.push_back(project_candidate(lcg_u, lcg_v));
            end
        end
        o_pending    <= expected_pts.size();
        o_fail_count <= fail_cnt;
    end

endmodule

/* bench/tb_sphere_point_sampler.sv */
`timescale 1ns / 1ps
// Top-level bench for the sphere point sampler: stimulus, seed programming and verdict.
module tb_sphere_point_sampler;

    localparam int FRAC_BITS     = sps_pkg::FRAC_BITS_DEF;
    // A candidate inside the disk runs the whole root loop; give the tail some margin
    localparam int SETTLE_CYCLES = 48;
    // Quiet gap between transactions after which the watchdog declares a hang
    localparam int WATCHDOG_MAX  = 4000;
    localparam int RAND_PHASES   = 8;
    localparam int DRAWS_PER_PH  = 48;

    localparam logic [sps_pkg::ADDR_W-1:0] ADDR_SEED_FIRST  = {sps_pkg::REG_SEED_FIRST, 2'b00};
    localparam logic [sps_pkg::ADDR_W-1:0] ADDR_SEED_SECOND = {sps_pkg::REG_SEED_SECOND, 2'b00};
    localparam logic [sps_pkg::DATA_W-1:0] SEED_MODULUS     = 32'h7FFF_FFFF;

    // Every block input starts at a known level
    logic                               i_clk     = 1'b0;
    logic                               i_rst_n   = 1'b0;
    logic                               psel      = 1'b0;
    logic                               penable   = 1'b0;
    logic                               pwrite    = 1'b0;
    logic [sps_pkg::ADDR_W-1:0]         paddr     = '0;
    logic [sps_pkg::DATA_W-1:0]         pwdata    = '0;
    logic [sps_pkg::DATA_W-1:0]         prdata;
    logic                               pready;
    logic                               i_valid   = 1'b0;
    logic                               o_stall;
    logic                               i_draw    = 1'b0;
    logic                               o_valid;
    logic                               i_stall   = 1'b0;
    logic                               o_accepted;
    logic signed [sps_pkg::COORD_W-1:0] o_coord_x, o_coord_y, o_coord_z;

    int   fail_count;
    int   pending;
    logic idle_on   = 1'b0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    sphere_point_sampler #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_stall, .i_draw,
        .o_valid, .i_stall, .o_accepted, .o_coord_x, .o_coord_y, .o_coord_z
    );

    sps_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk, .i_rst_n,
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_prdata(prdata),
        .i_draw_valid(i_valid), .i_draw_stall(o_stall), .i_draw(i_draw),
        .i_pt_valid(o_valid), .i_pt_stall(i_stall), .i_accepted(o_accepted),
        .i_coord_x(o_coord_x), .i_coord_y(o_coord_y), .i_coord_z(o_coord_z),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Back-pressure on the point channel: random stall bursts while idling is enabled,
    // a free-flowing sink otherwise.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(1, 18) - 1;
        end else begin
            i_stall    <= 1'b0;
        end
    end

    // Watchdog: count cycles with no transaction on any channel and bail out
    // when the design has clearly hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one draw transaction; hold it until the sampler takes it. A gap
    // drops valid first, so valid is never lowered and raised in one step.
    task automatic send_draw(input logic want_draw);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_draw  <= want_draw;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Two-phase register write: setup, then access until pready, then the bus goes idle
    task automatic write_reg(input logic [sps_pkg::ADDR_W-1:0] addr,
                             input logic [sps_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read back a register; the checker compares prdata on the access edge
    task automatic read_reg(input logic [sps_pkg::ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain: drop valid, wait until every predicted point has arrived, then let
    // the back end empty out before the seeds are touched.
    task automatic drain_points();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pick a seed word: half the time in range, half the time an edge value, always with a random top bit
    function automatic logic [sps_pkg::DATA_W-1:0] pick_seed();
        logic [sps_pkg::DATA_W-1:0] s;
        case ($urandom_range(0, 7))
            0:       s = 32'd0;
            1:       s = SEED_MODULUS;
            2:       s = 32'd1;
            3:       s = 32'h7FFF_FFFE;
            default: s = $urandom_range(1, 32'h7FFF_FFFE);
        endcase
        s[sps_pkg::DATA_W-1] = 1'($urandom_range(0, 1));
        return s;
    endfunction

    initial begin
        int draws;
        logic want_draw;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset seeds, idle transactions mixed in, no idling on either side
        read_reg(ADDR_SEED_FIRST);
        read_reg(ADDR_SEED_SECOND);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b1);
        drain_points();

        // Seed zero holds one generator at 0; a seed equal to the modulus
        // collapses to 0 on its first step.
        write_reg(ADDR_SEED_FIRST, 32'd0);
        write_reg(ADDR_SEED_SECOND, SEED_MODULUS);
        read_reg(ADDR_SEED_FIRST);
        read_reg(ADDR_SEED_SECOND);
        repeat (4) send_draw(1'b1);
        drain_points();

        write_reg(ADDR_SEED_FIRST, SEED_MODULUS);
        write_reg(ADDR_SEED_SECOND, 32'd0);
        repeat (3) send_draw(1'b1);
        drain_points();

        // Extremes of the legal range; the top data bit must be masked off
        write_reg(ADDR_SEED_FIRST, 32'd1);
        write_reg(ADDR_SEED_SECOND, 32'hFFFF_FFFE);
        read_reg(ADDR_SEED_SECOND);
        repeat (5) send_draw(1'b1);
        drain_points();

        // Random phases: one or both seeds new each time, some phases quiet, the last one with no idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph != RAND_PHASES - 1) && (ph % 3 != 1);
            case ($urandom_range(0, 2))
                0: write_reg(ADDR_SEED_FIRST, pick_seed());
                1: write_reg(ADDR_SEED_SECOND, pick_seed());
                default: begin
                    write_reg(ADDR_SEED_FIRST, pick_seed());
                    write_reg(ADDR_SEED_SECOND, pick_seed());
                end
            endcase
            read_reg(ADDR_SEED_FIRST);
            read_reg(ADDR_SEED_SECOND);
            draws = 0;
            while (draws < DRAWS_PER_PH) begin
                want_draw = ($urandom_range(0, 7) != 0);
                send_draw(want_draw);
                if (want_draw) draws++;
            end
            drain_points();
        end

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
